// ===== rtl/first_best_fit_block_allocator_core_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Included by the controller and datapath files; no other dependencies.
`ifndef FIRST_BEST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_BEST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define FBF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("allocator assertion failed");
// Condition must never be true outside reset.
`define FBF_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("allocator forbidden condition seen");
`else
`define FBF_ASSERT(label, clk, rst_n, prop)
`define FBF_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== rtl/fbf_pkg.sv =====
// Package for the first/best-fit block allocator: payload structs, codes,
// controller/datapath command and status types. No dependencies.
package fbf_pkg;

    // Default sizing
    localparam int NUM_BLOCKS_DEF = 8;
    localparam int SIZE_BITS_DEF  = 16;

    // Fixed field widths
    localparam int SLOT_W   = 3;
    localparam int AMOUNT_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'd1;
    localparam logic [CFG_DATA_W-1:0] BLOCKS_IN_USE_RST = 4'd8;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Fit mode codes
    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_BEST  = 1'b1;

    typedef struct packed {
        logic                command;
        logic [SLOT_W-1:0]   slot;
        logic [AMOUNT_W-1:0] amount;
        logic                batch_end;
    } t_request;

    typedef struct packed {
        logic                granted;
        logic [SLOT_W-1:0]   chosen_block;
        logic [AMOUNT_W-1:0] leftover;
        logic                batch_done;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // latch request, start first table read
        logic scan;     // evaluate one table entry
        logic finish;   // write back and load result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic new_is_load;  // request at the port is a load
        logic no_search;    // search length is zero
        logic stop;         // scan ends with the current entry
    } t_dp_status;

endpackage

// ===== rtl/fbf_ctrl.sv =====
// Allocator controller: sequences accept, table scan and finish.
// Depends on fbf_pkg and the assertion macro header.
`include "first_best_fit_block_allocator_core_macros.svh"

module fbf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  fbf_pkg::t_dp_status i_status,
    output fbf_pkg::t_dp_cmd    o_cmd,
    output logic                o_done
);
    import fbf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.new_is_load || i_status.no_search) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.stop) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_FINISH);
        end
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;

    `FBF_ASSERT(a_accept_goes_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    `FBF_ASSERT(a_finish_then_done, i_clk, i_rst_n, o_cmd.finish |=> (o_done && !busy))
    `FBF_ASSERT(a_done_single, i_clk, i_rst_n, o_done |=> !o_done)

endmodule

// ===== rtl/fbf_dp.sv =====
// Allocator datapath: free-size memory with valid bits, scan compare,
// best candidate tracking, write-back and result register.
// Depends on fbf_pkg and the assertion macro header.
`include "first_best_fit_block_allocator_core_macros.svh"

module fbf_dp #(
    parameter int NUM_BLOCKS = fbf_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fbf_pkg::SIZE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fbf_pkg::t_request                 i_request,
    input  logic                              i_fit_mode,
    input  logic [fbf_pkg::CFG_DATA_W-1:0]    i_blocks_in_use,
    input  fbf_pkg::t_dp_cmd                  i_cmd,
    output fbf_pkg::t_dp_status               o_status,
    output fbf_pkg::t_result                  o_result
);
    import fbf_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int LW    = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
    localparam int CW    = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;
    localparam int IW3   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam logic [LW-1:0] NUM_L = LW'(NUM_BLOCKS);

    // Free-size memory; entries read as zero until written
    logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_valid;
    logic [SIZE_BITS-1:0]  r_rd_data;
    logic                  r_rd_valid;

    t_request             r_req;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     r_last;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best;
    logic [SIZE_BITS-1:0] r_best_left;
    t_result              r_res;

    logic [LW-1:0]        biu_l;
    logic [LW-1:0]        lim;
    logic [LW-1:0]        lim_m1;
    logic [IDX_W-1:0]     rd_addr;
    logic [SIZE_BITS-1:0] have;
    logic [CW-1:0]        have_w;
    logic [CW-1:0]        amt_w;
    logic [CW-1:0]        diff_w;
    logic [SIZE_BITS-1:0] diff;
    logic                 fits;
    logic                 take;
    logic                 slot_ok;
    logic [IW3-1:0]       slot_w;
    logic [IW3-1:0]       best_w;
    logic [SIZE_BITS-1:0] load_val;
    logic [CW-1:0]        load_val_w;
    logic [CW-1:0]        best_left_w;
    logic                 we;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_data;

    // Search length, clamped to the table
    assign biu_l  = LW'(i_blocks_in_use);
    assign lim    = (biu_l > NUM_L) ? NUM_L : biu_l;
    assign lim_m1 = lim - LW'(1);

    // Read address: entry 0 at accept, then the next entry while scanning
    always_comb begin
        if (i_cmd.capture) begin
            rd_addr = '0;
        end else if (r_idx == r_last) begin
            rd_addr = r_idx;
        end else begin
            rd_addr = r_idx + IDX_W'(1);
        end
    end

    // Compare the entry under scan against the request
    assign have   = r_rd_valid ? r_rd_data : '0;
    assign have_w = CW'(have);
    assign amt_w  = CW'(r_req.amount);
    assign fits   = (have_w >= amt_w);
    assign diff_w = have_w - amt_w;
    assign diff   = diff_w[SIZE_BITS-1:0];
    assign take   = fits && (!r_found || ((i_fit_mode == FIT_BEST) && (diff < r_best_left)));

    // Load and result field shaping
    assign slot_ok     = (LW'(r_req.slot) < NUM_L);
    assign slot_w      = IW3'(r_req.slot);
    assign best_w      = IW3'(r_best);
    assign load_val    = amt_w[SIZE_BITS-1:0];
    assign load_val_w  = CW'(load_val);
    assign best_left_w = CW'(r_best_left);

    // Single write port, used at finish
    assign we      = i_cmd.finish &&
                     ((r_req.command == CMD_LOAD) ? slot_ok : r_found);
    assign wr_addr = (r_req.command == CMD_LOAD) ? slot_w[IDX_W-1:0] : r_best;
    assign wr_data = (r_req.command == CMD_LOAD) ? load_val : r_best_left;

    // Memory array, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Valid bits and their registered read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (we) begin
                r_valid[wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[rd_addr];
        end
    end

    // Request latch and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_idx   <= '0;
        end else if (i_cmd.capture) begin
            r_found <= 1'b0;
            r_idx   <= '0;
        end else if (i_cmd.scan) begin
            if (take) begin
                r_found <= 1'b1;
            end
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_request;
            r_last <= lim_m1[IDX_W-1:0];
        end
        if (i_cmd.scan && take) begin
            r_best      <= r_idx;
            r_best_left <= diff;
        end
        if (i_cmd.finish) begin
            r_res.batch_done <= r_req.batch_end;
            if (r_req.command == CMD_LOAD) begin
                r_res.granted      <= 1'b0;
                r_res.chosen_block <= r_req.slot;
                r_res.leftover     <= slot_ok ? load_val_w[AMOUNT_W-1:0] : '0;
            end else if (r_found) begin
                r_res.granted      <= 1'b1;
                r_res.chosen_block <= best_w[SLOT_W-1:0];
                r_res.leftover     <= best_left_w[AMOUNT_W-1:0];
            end else begin
                r_res.granted      <= 1'b0;
                r_res.chosen_block <= '0;
                r_res.leftover     <= '0;
            end
        end
    end

    assign o_status.new_is_load = (i_request.command == CMD_LOAD);
    assign o_status.no_search   = (i_blocks_in_use == '0);
    assign o_status.stop        = (fits && (i_fit_mode == FIT_FIRST)) || (r_idx == r_last);
    assign o_result             = r_res;

    `FBF_ASSERT(a_scan_in_range, i_clk, i_rst_n, i_cmd.scan |-> (r_idx <= r_last))
    `FBF_ASSERT(a_capture_clears_found, i_clk, i_rst_n, i_cmd.capture |=> !r_found)
    `FBF_NEVER(a_grant_in_range, i_clk, i_rst_n, i_cmd.finish && r_found && (r_best > r_last))

endmodule

// ===== rtl/first_best_fit_block_allocator_core.sv =====
// Top level of the first/best-fit block allocator: configuration registers,
// controller and datapath. Depends on fbf_pkg, fbf_ctrl and fbf_dp.
//
//  Port group      Direction  Handshake             Contents
//  request         in         start & !busy         i_request (t_request)
//  result          out        o_done, one cycle     o_result (t_result)
//  configuration   in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// A load, or an allocate with a zero search length, goes from accept straight
// to the finish state. An allocate scans at most min(blocks_in_use,
// NUM_BLOCKS) blocks before its finish; the table memory is read one entry a
// cycle. First fit stops at the first fitting block.
// busy falls in the cycle o_done rises, so the next request may start then.
// Synchronous active-low reset; the table reads as zero after reset.
// The result has no back-pressure: o_done is high for exactly one cycle.
module first_best_fit_block_allocator_core #(
    parameter int NUM_BLOCKS = fbf_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fbf_pkg::SIZE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  fbf_pkg::t_request              i_request,
    output logic                           o_done,
    output fbf_pkg::t_result               o_result,
    input  logic                           i_cfg_we,
    input  logic [fbf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fbf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fbf_pkg::*;

    logic                  r_fit_mode;
    logic [CFG_DATA_W-1:0] r_blocks_in_use;
    t_dp_cmd               dp_cmd;
    t_dp_status            dp_status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode      <= FIT_FIRST;
            r_blocks_in_use <= BLOCKS_IN_USE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FIT_MODE:      r_fit_mode      <= i_cfg_data[0];
                REG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fbf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_done   (o_done)
    );

    fbf_dp #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_request       (i_request),
        .i_fit_mode      (r_fit_mode),
        .i_blocks_in_use (r_blocks_in_use),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .o_result        (o_result)
    );

endmodule

// ===== dv/first_best_fit_block_allocator_core_tb.sv =====
// Self-checking testbench for the first/best-fit block allocator core.
// Predicts every grant from a local free-size table; depends on fbf_pkg and
// first_best_fit_block_allocator_core.
`timescale 1ns / 1ps

module first_best_fit_block_allocator_core_tb;
    import fbf_pkg::*;

    localparam int TABLE_DEPTH  = NUM_BLOCKS_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;

    // DUT signals
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_request              i_request = '0;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Local copy of allocator state and settings
    logic [AMOUNT_W-1:0]   free_size [TABLE_DEPTH];
    logic                  fit_sel;
    logic [CFG_DATA_W-1:0] search_len;

    t_result pending_grants[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      burst_left = 0;
    t_result seen_grant;
    t_result want_grant;

    first_best_fit_block_allocator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_request  (i_request),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_grants.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Predict the result of one request and update the local table
    function automatic t_result predict_grant(t_request r);
        t_result             res;
        int                  limit;
        logic                found;
        logic                stop;
        logic [SLOT_W-1:0]   pick;
        logic [AMOUNT_W-1:0] pick_left;
        logic [AMOUNT_W-1:0] diff;
        res = '0;
        res.batch_done = r.batch_end;
        if (r.command == CMD_LOAD) begin
            free_size[r.slot] = r.amount;
            res.chosen_block = r.slot;
            res.leftover = r.amount;
        end else begin
            limit = (search_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(search_len);
            found = 1'b0;
            stop = 1'b0;
            pick = '0;
            pick_left = '0;
            for (int j = 0; j < limit; j++) begin
                if (!stop && free_size[SLOT_W'(j)] >= r.amount) begin
                    diff = free_size[SLOT_W'(j)] - r.amount;
                    if (!found || (fit_sel == FIT_BEST && diff < pick_left)) begin
                        found = 1'b1;
                        pick = SLOT_W'(j);
                        pick_left = diff;
                    end
                    if (fit_sel == FIT_FIRST)
                        stop = 1'b1;
                end
            end
            if (found) begin
                free_size[pick] = pick_left;
                res.granted = 1'b1;
                res.chosen_block = pick;
                res.leftover = pick_left;
            end
        end
        return res;
    endfunction

    // Result checker: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            seen_grant = o_result;
            if (pending_grants.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result %p at cycle %0d", seen_grant, cycle_count);
            end else begin
                want_grant = pending_grants.pop_front();
                if (seen_grant.granted !== want_grant.granted
                        || seen_grant.chosen_block !== want_grant.chosen_block
                        || seen_grant.leftover !== want_grant.leftover
                        || seen_grant.batch_done !== want_grant.batch_done) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch at cycle %0d: expected %p, got %p",
                                 cycle_count, want_grant, seen_grant);
                end
            end
        end
    end

    // Send one request and record its prediction once accepted
    task automatic send_request(input t_request r);
        start <= 1'b1;
        i_request <= r;
        do @(posedge i_clk); while (busy);
        pending_grants.push_back(predict_grant(r));
    endtask

    // Sender pacing: bursts of back-to-back requests with random gaps
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            i_request <= t_request'($urandom);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic issue(input logic cmd, input logic [SLOT_W-1:0] slot,
                         input logic [AMOUNT_W-1:0] amount, input logic last);
        t_request r;
        r.command = cmd;
        r.slot = slot;
        r.amount = amount;
        r.batch_end = last;
        send_request(r);
        pace_sender();
    endtask

    // Hold off until every expected result has come and the core is idle
    task automatic drain_results();
        start <= 1'b0;
        i_request <= t_request'($urandom);
        do @(posedge i_clk); while (pending_grants.size() != 0 || busy);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == REG_FIT_MODE)
            fit_sel = data[0];
        else if (idx == REG_BLOCKS_IN_USE)
            search_len = data;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic mode, input logic [CFG_DATA_W-1:0] len);
        drain_results();
        write_register(REG_FIT_MODE, {(CFG_DATA_W-1)'($urandom_range(0, 7)), mode});
        write_register(REG_BLOCKS_IN_USE, len);
    endtask

    // Table is all zero after reset: a zero request fits, anything else fails
    task automatic test_reset_state();
        issue(CMD_ALLOC, 3'd5, 16'd0, 1'b0);
        issue(CMD_ALLOC, 3'd2, 16'd1, 1'b1);
    endtask

    // Loads into every slot with the amount extremes
    task automatic test_loads();
        issue(CMD_LOAD, 3'd0, 16'hFFFF, 1'b0);
        issue(CMD_LOAD, 3'd1, 16'h0000, 1'b1);
        issue(CMD_LOAD, 3'd2, 16'h8000, 1'b0);
        issue(CMD_LOAD, 3'd3, 16'h7FFF, 1'b1);
        issue(CMD_LOAD, 3'd4, 16'd100, 1'b0);
        issue(CMD_LOAD, 3'd5, 16'd50, 1'b0);
        issue(CMD_LOAD, 3'd6, 16'd50, 1'b1);
        issue(CMD_LOAD, 3'd7, 16'd200, 1'b0);
    endtask

    // First fit: zero request, oversize refusal, exact fit, skip to next block
    task automatic test_first_fit();
        set_mode(FIT_FIRST, 4'd8);
        issue(CMD_ALLOC, 3'd7, 16'd40, 1'b0);
        issue(CMD_ALLOC, 3'd0, 16'hFFFF, 1'b0);
        issue(CMD_ALLOC, 3'd0, 16'd0, 1'b1);
        issue(CMD_ALLOC, 3'd0, 16'hFFD7, 1'b0);
        issue(CMD_ALLOC, 3'd0, 16'd30, 1'b1);
    endtask

    // Best fit: tie on equal leftovers goes to the lower index
    task automatic test_best_fit();
        set_mode(FIT_BEST, 4'd8);
        issue(CMD_ALLOC, 3'd0, 16'd50, 1'b0);
        issue(CMD_ALLOC, 3'd0, 16'd50, 1'b0);
        issue(CMD_ALLOC, 3'd0, 16'd45, 1'b1);
    endtask

    // Search length of zero, one, and beyond the table
    task automatic test_search_length();
        set_mode(FIT_BEST, 4'd0);
        issue(CMD_ALLOC, 3'd0, 16'd0, 1'b1);
        set_mode(FIT_FIRST, 4'd1);
        issue(CMD_ALLOC, 3'd0, 16'd1, 1'b0);
        set_mode(FIT_BEST, 4'd15);
        issue(CMD_ALLOC, 3'd0, 16'd150, 1'b1);
    endtask

    // Random phases over several settings; requests mostly sized to fit
    task automatic test_random();
        logic [CFG_DATA_W-1:0] lens [8] = '{4'd8, 4'd1, 4'd15, 4'd4, 4'd0, 4'd9, 4'd3, 4'd8};
        logic [AMOUNT_W-1:0]   amt;
        logic [SLOT_W-1:0]     s;
        logic [AMOUNT_W-1:0]   have;
        for (int phase = 0; phase < 8; phase++) begin
            set_mode(phase[0], lens[phase]);
            for (int n = 0; n < 50; n++) begin
                s = SLOT_W'($urandom);
                if ($urandom_range(0, 3) == 0) begin
                    issue(CMD_LOAD, s, AMOUNT_W'($urandom), 1'($urandom));
                end else begin
                    have = free_size[SLOT_W'($urandom_range(0, TABLE_DEPTH - 1))];
                    case ($urandom_range(0, 9))
                        0: amt = '0;
                        1: amt = '1;
                        2: amt = AMOUNT_W'($urandom);
                        3, 4: amt = have;
                        5, 6: amt = have - AMOUNT_W'($urandom_range(0, 64));
                        default: amt = have >> $urandom_range(1, 6);
                    endcase
                    issue(CMD_ALLOC, s, amt, 1'($urandom));
                end
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
        end
    endtask

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            free_size[SLOT_W'(i)] = '0;
        fit_sel = FIT_FIRST;
        search_len = BLOCKS_IN_USE_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_loads();
        test_first_fit();
        test_best_fit();
        test_search_length();
        test_random();

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_grants.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
